// ===== rtl/core/tjq_pkg.sv =====
// shared types and codes for the timed job queue
`default_nettype none
package tjq_pkg;

  // function codes of an input item
  localparam logic [1:0] FUNC_ENQ    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // status codes of a result item
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_UNMET    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // number of job slots
  localparam int unsigned QueueDepth = 16;

  localparam int unsigned CapWidth  = 5;
  localparam int unsigned CapReset  = 16;
  localparam int unsigned PosWidth  = 4;
  localparam int unsigned LenWidth  = 5;
  localparam int unsigned ProgWidth = 9;
  localparam int unsigned FracBits  = 8;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic enq;
    logic tick;
    logic srd;
    logic scmp;
    logic shrd;
    logic shwr;
    logic shdone;
    logic hrd;
    logic hld;
    logic dinit;
    logic dstep;
  } tjq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       count_zero;
    logic       pop;
    logic       match;
    logic       search_last;
    logic       shift_more;
    logic       reload_head;
    logic       div_done;
  } tjq_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/timed_job_queue_with_cancel.sv =====
// Timed job queue with cancel: FIFO of jobs with a head service timer.
// Input channel in_valid_i/in_ready_o carries one item: func_i selects enqueue,
// cancel, tick or no operation; job_id_i, job_duration_i, requirement_ok_i and
// elapsed_i are its operands. Each item gives exactly one result on the
// out_valid_o/out_ready_i channel: status, slot of an enqueued job, finish
// flag and id, queue length after the item, and head progress in Q1.8.
// The user must write the capacity register with cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce this. One item is processed
// at a time. An enqueue, a tick and a cancel each run their own step first; a
// cancel reads and compares slot by slot until a match or the last job. A
// tick that finishes the head or a cancel that finds its job then compacts
// the queue, moving each later job up one slot, and reloads the new head if
// the head was removed and jobs remain. Every item ends with the eight-step
// progress divider. The result is held until out_ready_i is high and the
// next item is taken in the cycle after that. Reset empties the queue,
// clears the timer and sets the capacity to 16; job slots stay unwritten.
`default_nettype none
module timed_job_queue_with_cancel
  import tjq_pkg::*;
#(
  parameter int unsigned ID_WIDTH    = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CapWidth-1:0]   cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            func_i,
  input  wire logic [ID_WIDTH-1:0]   job_id_i,
  input  wire logic [TIME_WIDTH-1:0] job_duration_i,
  input  wire logic                  requirement_ok_i,
  input  wire logic [TIME_WIDTH-1:0] elapsed_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 status_o,
  output logic [PosWidth-1:0]        position_o,
  output logic                       finished_o,
  output logic [ID_WIDTH-1:0]        finished_id_o,
  output logic [LenWidth-1:0]        queue_length_o,
  output logic [ProgWidth-1:0]       progress_o
);

  tjq_cmd_t cmd;
  tjq_sts_t sts;

  // sequencer
  tjq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  tjq_dp #(
    .ID_WIDTH    (ID_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (func_i),
    .job_id_i         (job_id_i),
    .job_duration_i   (job_duration_i),
    .requirement_ok_i (requirement_ok_i),
    .elapsed_i        (elapsed_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .position_o       (position_o),
    .finished_o       (finished_o),
    .finished_id_o    (finished_id_o),
    .queue_length_o   (queue_length_o),
    .progress_o       (progress_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tjq_ctrl.sv =====
// sequencer for the timed job queue
`default_nettype none
module tjq_ctrl
  import tjq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire tjq_sts_t sts_i,
  output tjq_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ENQ   = 4'd1;
  localparam logic [3:0] S_TICK  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_SHCHK = 4'd5;
  localparam logic [3:0] S_SHRD  = 4'd6;
  localparam logic [3:0] S_SHWR  = 4'd7;
  localparam logic [3:0] S_HRD   = 4'd8;
  localparam logic [3:0] S_HLD   = 4'd9;
  localparam logic [3:0] S_DIV0  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DIV0;
          if (sts_i.func == FUNC_ENQ) begin
            state_d = S_ENQ;
          end else if (sts_i.func == FUNC_CANCEL) begin
            state_d = S_SRD;
          end else if (sts_i.func == FUNC_TICK) begin
            state_d = S_TICK;
          end
        end
      end
      S_ENQ: begin
        cmd_o.enq = 1'b1;
        state_d = S_DIV0;
      end
      S_TICK: begin
        cmd_o.tick = 1'b1;
        state_d = sts_i.pop ? S_SHCHK : S_DIV0;
      end
      S_SRD: begin
        if (sts_i.count_zero) begin
          cmd_o.scmp = 1'b1;
          state_d = S_DIV0;
        end else begin
          cmd_o.srd = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd_o.scmp = 1'b1;
        if (sts_i.match) begin
          state_d = S_SHCHK;
        end else if (sts_i.search_last) begin
          state_d = S_DIV0;
        end else begin
          state_d = S_SRD;
        end
      end
      S_SHCHK: begin
        if (sts_i.shift_more) begin
          state_d = S_SHRD;
        end else begin
          cmd_o.shdone = 1'b1;
          state_d = sts_i.reload_head ? S_HRD : S_DIV0;
        end
      end
      S_SHRD: begin
        cmd_o.shrd = 1'b1;
        state_d = S_SHWR;
      end
      S_SHWR: begin
        cmd_o.shwr = 1'b1;
        state_d = S_SHCHK;
      end
      S_HRD: begin
        cmd_o.hrd = 1'b1;
        state_d = S_HLD;
      end
      S_HLD: begin
        cmd_o.hld = 1'b1;
        state_d = S_DIV0;
      end
      S_DIV0: begin
        cmd_o.dinit = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.dstep = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  // accepted item leaves idle at once
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer stayed idle after accepting an item");

  // a pending result is held until taken
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // division runs only between setup and result
  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.dstep))
    else $error("result shown without a finished division");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tjq_dp.sv =====
// storage, search, compaction, timer and progress divider of the job queue
`default_nettype none
module tjq_dp
  import tjq_pkg::*;
#(
  parameter int unsigned ID_WIDTH    = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CapWidth-1:0]   cfg_wdata_i,
  input  wire logic [1:0]            func_i,
  input  wire logic [ID_WIDTH-1:0]   job_id_i,
  input  wire logic [TIME_WIDTH-1:0] job_duration_i,
  input  wire logic                  requirement_ok_i,
  input  wire logic [TIME_WIDTH-1:0] elapsed_i,
  input  wire tjq_cmd_t              cmd_i,
  output tjq_sts_t                   sts_o,
  output logic [1:0]                 status_o,
  output logic [PosWidth-1:0]        position_o,
  output logic                       finished_o,
  output logic [ID_WIDTH-1:0]        finished_id_o,
  output logic [LenWidth-1:0]        queue_length_o,
  output logic [ProgWidth-1:0]       progress_o
);

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned KW = (CW > CapWidth) ? CW : CapWidth;
  localparam int unsigned EW = ID_WIDTH + TIME_WIDTH;

  // control state
  logic [CW-1:0]         count_q;
  logic [TIME_WIDTH-1:0] timer_q;
  logic [CapWidth-1:0]   cap_q;

  // latched item and working registers
  logic [ID_WIDTH-1:0]   id_q;
  logic [TIME_WIDTH-1:0] dur_q;
  logic                  req_q;
  logic [TIME_WIDTH-1:0] el_q;
  logic [CW-1:0]         idx_q;
  logic                  rm_head_q;
  logic [ID_WIDTH-1:0]   hid_q;
  logic [TIME_WIDTH-1:0] hdur_q;
  logic [TIME_WIDTH:0]   rem_q;
  logic [FracBits-1:0]   quo_q;
  logic [2:0]            dcnt_q;
  logic [1:0]            status_q;
  logic [PosWidth-1:0]   pos_q;
  logic                  fin_q;
  logic [ID_WIDTH-1:0]   finid_q;

  // job memory
  logic [EW-1:0] mem_q [QueueDepth];
  logic [EW-1:0] rdata_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] raddr, waddr;
  logic [EW-1:0] wdata;

  logic [KW-1:0]         cnt_ext;
  logic                  full, enq_ok, match, pop;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] tsat;
  logic [CW-1:0]         idx_inc;
  logic [TIME_WIDTH:0]   rem_sh;
  logic                  rem_ge;

  assign cnt_ext = KW'(count_q);
  assign full    = (cnt_ext >= KW'(cap_q)) || (count_q == CW'(QueueDepth));
  assign enq_ok  = !full && req_q;
  assign idx_inc = idx_q + CW'(1);
  assign match   = (rdata_q[EW-1:TIME_WIDTH] == id_q);

  // saturating timer add and finish check
  assign sum  = {1'b0, timer_q} + {1'b0, el_q};
  assign tsat = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
  assign pop  = (count_q != '0) && (tsat >= hdur_q);

  // one restoring division step
  assign rem_sh = {rem_q[TIME_WIDTH-1:0], 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, hdur_q});

  // status to sequencer
  always_comb begin
    sts_o             = '0;
    sts_o.func        = func_i;
    sts_o.count_zero  = (count_q == '0);
    sts_o.pop         = pop;
    sts_o.match       = match;
    sts_o.search_last = (idx_inc >= count_q);
    sts_o.shift_more  = (idx_inc < count_q);
    sts_o.reload_head = rm_head_q && (count_q > CW'(1));
    sts_o.div_done    = (dcnt_q == 3'd7);
  end

  // memory port selection
  always_comb begin
    rd_en = cmd_i.srd || cmd_i.shrd || cmd_i.hrd;
    raddr = '0;
    if (cmd_i.srd) begin
      raddr = idx_q[AW-1:0];
    end else if (cmd_i.shrd) begin
      raddr = idx_inc[AW-1:0];
    end
    wr_en = (cmd_i.enq && enq_ok) || cmd_i.shwr;
    waddr = cmd_i.enq ? count_q[AW-1:0] : idx_q[AW-1:0];
    wdata = cmd_i.enq ? {id_q, dur_q} : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // count, timer and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      timer_q <= '0;
      cap_q   <= CapWidth'(CapReset);
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.enq && enq_ok) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.shdone) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.tick && (count_q != '0)) begin
        timer_q <= pop ? '0 : tsat;
      end
      if (cmd_i.scmp && (count_q != '0) && match && (idx_q == '0)) begin
        timer_q <= '0;
      end
    end
  end

  // item, head copy, search index and result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q      <= job_id_i;
      dur_q     <= job_duration_i;
      req_q     <= requirement_ok_i;
      el_q      <= elapsed_i;
      idx_q     <= '0;
      rm_head_q <= 1'b0;
      status_q  <= ST_DONE;
      pos_q     <= '0;
      fin_q     <= 1'b0;
      finid_q   <= '0;
    end
    if (cmd_i.enq) begin
      if (full) begin
        status_q <= ST_FULL;
      end else if (!req_q) begin
        status_q <= ST_UNMET;
      end else begin
        pos_q <= cnt_ext[PosWidth-1:0];
        if (count_q == '0) begin
          hid_q  <= id_q;
          hdur_q <= dur_q;
        end
      end
    end
    if (cmd_i.tick && pop) begin
      fin_q     <= 1'b1;
      finid_q   <= hid_q;
      rm_head_q <= 1'b1;
    end
    if (cmd_i.scmp) begin
      if (count_q == '0) begin
        status_q <= ST_NOTFOUND;
      end else if (match) begin
        rm_head_q <= (idx_q == '0);
      end else if (idx_inc >= count_q) begin
        status_q <= ST_NOTFOUND;
      end else begin
        idx_q <= idx_inc;
      end
    end
    if (cmd_i.shwr) begin
      idx_q <= idx_inc;
    end
    if (cmd_i.hld) begin
      hid_q  <= rdata_q[EW-1:TIME_WIDTH];
      hdur_q <= rdata_q[TIME_WIDTH-1:0];
    end
    if (cmd_i.dinit) begin
      rem_q  <= {1'b0, timer_q};
      quo_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.dstep) begin
      rem_q  <= rem_ge ? (rem_sh - {1'b0, hdur_q}) : rem_sh;
      quo_q  <= {quo_q[FracBits-2:0], rem_ge};
      dcnt_q <= dcnt_q + 3'd1;
    end
  end

  // result fields
  assign status_o       = status_q;
  assign position_o     = pos_q;
  assign finished_o     = fin_q;
  assign finished_id_o  = finid_q;
  assign queue_length_o = cnt_ext[LenWidth-1:0];
  assign progress_o     = ((count_q == '0) || (timer_q >= hdur_q)) ?
                          ProgWidth'(1 << FracBits) : {1'b0, quo_q};

`ifndef SYNTH
  // fill never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QueueDepth))
    else $error("job count beyond queue depth");

  // an empty queue carries no head time
  a_empty_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> timer_q == '0)
    else $error("timer running on an empty queue");

  // compaction writes only inside the filled region
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shwr |-> idx_inc < count_q)
    else $error("compaction write past the last job");
`endif

endmodule
`default_nettype wire

// ===== dv/timed_job_queue_with_cancel_test.sv =====
// self-checking testbench for the timed job queue with cancel
`default_nettype none
module timed_job_queue_with_cancel_test;
  import tjq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  position;
    logic        finished;
    logic [15:0] finished_id;
    logic [4:0]  queue_length;
    logic [8:0]  progress;
  } res_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] id;
    logic [31:0] dur;
    logic        req;
    logic [31:0] el;
  } job_item_t;

  // directed row: item plus optional typed-in result
  typedef struct packed {
    job_item_t   item;
    logic        has_res;
    res_t        res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CapWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = FUNC_NOP;
  logic [15:0] job_id_i = '0;
  logic [31:0] job_duration_i = '0;
  logic requirement_ok_i = 1'b0;
  logic [31:0] elapsed_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [PosWidth-1:0] position_o;
  logic finished_o;
  logic [15:0] finished_id_o;
  logic [LenWidth-1:0] queue_length_o;
  logic [ProgWidth-1:0] progress_o;

  timed_job_queue_with_cancel u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .func_i, .job_id_i, .job_duration_i, .requirement_ok_i, .elapsed_i,
    .out_valid_o, .out_ready_i, .status_o, .position_o, .finished_o,
    .finished_id_o, .queue_length_o, .progress_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow queue state
  logic [15:0] q_ids [Depth];
  logic [31:0] q_durs [Depth];
  int unsigned q_len;
  logic [31:0] q_timer;
  logic [4:0] q_cap;

  res_t expected_q[$];
  int err_cnt = 0;
  bit quiet = 1'b0;

  function automatic void drop_slot(int unsigned k);
    for (int unsigned i = k; i + 1 < q_len; i++) begin
      q_ids[i] = q_ids[i+1];
      q_durs[i] = q_durs[i+1];
    end
    q_len--;
  endfunction

  // head timer over duration, Q1.8, clamped
  function automatic logic [8:0] head_fraction();
    logic [63:0] scaled;
    if (q_len == 0) return 9'd256;
    if (q_timer >= q_durs[0]) return 9'd256;
    scaled = ({32'd0, q_timer} << 8) / {32'd0, q_durs[0]};
    return scaled[8:0];
  endfunction

  function automatic res_t queue_apply(job_item_t it);
    res_t r;
    int unsigned lim;
    int unsigned i;
    logic [32:0] sum;
    r = '0;
    lim = (q_cap < Depth) ? q_cap : Depth;
    case (it.func)
      FUNC_ENQ: begin
        if (q_len >= lim) r.status = ST_FULL;
        else if (!it.req) r.status = ST_UNMET;
        else begin
          r.position = q_len[3:0];
          q_ids[q_len] = it.id;
          q_durs[q_len] = it.dur;
          q_len++;
        end
      end
      FUNC_CANCEL: begin
        for (i = 0; i < q_len; i++) if (q_ids[i] == it.id) break;
        if (i >= q_len) r.status = ST_NOTFOUND;
        else begin
          if (i == 0) q_timer = '0;
          drop_slot(i);
        end
      end
      FUNC_TICK: begin
        if (q_len > 0) begin
          sum = {1'b0, q_timer} + {1'b0, it.el};
          q_timer = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (q_timer >= q_durs[0]) begin
            r.finished = 1'b1;
            r.finished_id = q_ids[0];
            drop_slot(0);
            q_timer = '0;
          end
        end
      end
      default: ;
    endcase
    r.queue_length = q_len[4:0];
    r.progress = head_fraction();
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); err_cnt++;
        end
        if (position_o !== e.position) begin
          $error("position exp %0d got %0d", e.position, position_o); err_cnt++;
        end
        if (finished_o !== e.finished) begin
          $error("finished exp %0d got %0d", e.finished, finished_o); err_cnt++;
        end
        if (finished_id_o !== e.finished_id) begin
          $error("finished_id exp %0d got %0d", e.finished_id, finished_id_o);
          err_cnt++;
        end
        if (queue_length_o !== e.queue_length) begin
          $error("queue_length exp %0d got %0d", e.queue_length, queue_length_o);
          err_cnt++;
        end
        if (progress_o !== e.progress) begin
          $error("progress exp %0d got %0d", e.progress, progress_o); err_cnt++;
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // valid stays up after acceptance until the next idle gap or drain
  task automatic send_item(job_item_t it, bit has_res, res_t typed);
    res_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= it.func;
    job_id_i <= it.id;
    job_duration_i <= it.dur;
    requirement_ok_i <= it.req;
    elapsed_i <= it.el;
    do @(posedge clk_i); while (!in_ready_o);
    p = queue_apply(it);
    if (has_res && p !== typed) begin
      $error("directed row result exp %h predictor %h", typed, p);
      err_cnt++;
    end
    expected_q.insert(expected_q.size(), has_res ? typed : p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [4:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    q_cap = v;
  endtask

  function automatic job_item_t mk(logic [1:0] f, logic [15:0] id, logic [31:0] d,
                                   logic rq, logic [31:0] el);
    job_item_t it;
    it.func = f; it.id = id; it.dur = d; it.req = rq; it.el = el;
    return it;
  endfunction

  function automatic res_t rs(logic [1:0] st, logic [3:0] pos, logic fin,
                              logic [15:0] fid, logic [4:0] len, logic [8:0] pr);
    res_t r;
    r.status = st; r.position = pos; r.finished = fin; r.finished_id = fid;
    r.queue_length = len; r.progress = pr;
    return r;
  endfunction

  // random item biased toward live ids
  function automatic job_item_t rand_item();
    job_item_t it;
    int unsigned sel;
    it.id = 16'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) it.id = 16'($urandom);
    if (q_len > 0 && $urandom_range(0, 1)) it.id = q_ids[$urandom_range(0, q_len - 1)];
    sel = $urandom_range(0, 3);
    case (sel)
      0: it.dur = $urandom;
      1: it.dur = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: it.dur = $urandom_range(0, 1000);
    endcase
    sel = $urandom_range(0, 3);
    case (sel)
      0: it.el = $urandom;
      1: it.el = 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: it.el = $urandom_range(0, 400);
    endcase
    it.req = ($urandom_range(0, 7) != 0);
    sel = $urandom_range(0, 19);
    if (sel < 8) it.func = FUNC_ENQ;
    else if (sel < 12) it.func = FUNC_CANCEL;
    else if (sel < 19) it.func = FUNC_TICK;
    else it.func = FUNC_NOP;
    return it;
  endfunction

  row_t dir_rows[$];

  // append one row to the directed table
  function automatic void add_row(job_item_t it, bit has_res, res_t r);
    row_t row;
    row.item = it;
    row.has_res = has_res;
    row.res = r;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    logic [4:0] caps [5];
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5};
    q_len = 0;
    q_timer = '0;
    q_cap = 5'd16;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    add_row(mk(FUNC_TICK, 16'd0, 32'd1, 1'b1, 32'hFFFF_FFFF), 1'b1,
            rs(ST_DONE, 4'd0, 1'b0, 16'd0, 5'd0, 9'd256));
    add_row(mk(FUNC_CANCEL, 16'hFFFF, 32'd1, 1'b1, 32'd0), 1'b1,
            rs(ST_NOTFOUND, 4'd0, 1'b0, 16'd0, 5'd0, 9'd256));
    add_row(mk(FUNC_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd0), 1'b1,
            rs(ST_DONE, 4'd0, 1'b0, 16'd0, 5'd1, 9'd0));
    add_row(mk(FUNC_ENQ, 16'h0000, 32'd0, 1'b0, 32'd0), 1'b1,
            rs(ST_UNMET, 4'd0, 1'b0, 16'd0, 5'd1, 9'd0));
    add_row(mk(FUNC_ENQ, 16'h0000, 32'd0, 1'b1, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_ENQ, 16'h0000, 32'd4, 1'b1, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_TICK, 16'd0, 32'd0, 1'b0, 32'h8000_0000), 1'b0, '0);
    add_row(mk(FUNC_TICK, 16'd0, 32'd0, 1'b0, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk(FUNC_NOP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk(FUNC_TICK, 16'd0, 32'd0, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_ENQ, 16'h5555, 32'd3, 1'b1, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_ENQ, 16'h5555, 32'd7, 1'b1, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_TICK, 16'd0, 32'd0, 1'b0, 32'd1), 1'b0, '0);
    add_row(mk(FUNC_CANCEL, 16'h0000, 32'd0, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_CANCEL, 16'h5555, 32'd0, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_TICK, 16'd0, 32'd0, 1'b0, 32'd2), 1'b0, '0);
    add_row(mk(FUNC_TICK, 16'd0, 32'd0, 1'b0, 32'd5), 1'b0, '0);
    add_row(mk(FUNC_TICK, 16'd0, 32'd0, 1'b0, 32'd9), 1'b0, '0);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_res, dir_rows[i].res);
    drain();

    // full wins over unmet
    set_capacity(5'd0);
    send_item(mk(FUNC_ENQ, 16'h1234, 32'd9, 1'b0, 32'd0), 1'b1,
              rs(ST_FULL, 4'd0, 1'b0, 16'd0, 5'(q_len), head_fraction()));
    drain();

    // random phases across capacity settings
    foreach (caps[c]) begin
      set_capacity(caps[c]);
      if (c == 4) quiet = 1'b1;
      for (int n = 0; n < 340; n++) send_item(rand_item(), 1'b0, '0);
      drain();
    end

    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
